// ===== hdl/idba_pkg.sv =====
package idba_pkg;

    localparam int MAP_BITS  = 16384;
    localparam int WORD_BITS = 8;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = $clog2(MAP_WORDS);
    localparam int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int SLOT_W    = $clog2(MAP_BITS);
    localparam int CNT_W     = $clog2(MAP_BITS + 1);
    localparam int ID_W      = 16;
    localparam int IDC_W     = 15;
    localparam int SPAN_W    = ID_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [ID_W-1:0]  BASE_ID_RESET  = 16'd300;
    localparam logic [IDC_W-1:0] ID_COUNT_RESET = 15'd9701;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT = 1'd1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef logic [WORD_BITS-1:0] map_word_t;

    typedef struct packed {
        logic            opcode;
        logic [ID_W-1:0] release_id;
    } in_word_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] id;
    } out_word_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        map_word_t         wr_data;
    } ram_req_t;

    typedef struct packed {
        logic [ID_W-1:0]  base_id;
        logic [CNT_W-1:0] active_count;
    } cfg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_REL_WRITE,
        S_DONE
    } state_t;

endpackage

// ===== hdl/id_bitmap_allocator_unit.sv =====
// Lowest-free identifier allocator over a 2048 x 8 in-use bitmap held in one
// synchronous RAM. After reset the block clears every map word in turn and
// takes no word in that time; configuration writes are taken at any time.
// A release reads its map word in S_DECODE, clears its bit in S_REL_WRITE and
// passes the result to the output register from S_DONE; a release out of range
// goes from S_DECODE straight to S_DONE. An allocate reads one map word per
// cycle from the lowest word upward through the single read port, and stops at
// the first free identifier or at the last word of the active range. A finished
// result waits in the output register while the next word is accepted.
module id_bitmap_allocator_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [idba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [idba_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  idba_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output idba_pkg::out_word_t             m_data
);
    import idba_pkg::*;

    cfg_t      cfg;
    ram_req_t  ram_req;
    map_word_t ram_rd_data;

    idba_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    idba_map_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    idba_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

endmodule

// ===== hdl/idba_map_ram.sv =====
module idba_map_ram (
    input  logic                aclk,
    input  idba_pkg::ram_req_t  req,
    output idba_pkg::map_word_t rd_data
);
    import idba_pkg::*;

    map_word_t mem [MAP_WORDS];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== hdl/idba_cfg_regs.sv =====
module idba_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [idba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [idba_pkg::CFG_DATA_W-1:0]   cfg_data,
    output idba_pkg::cfg_t                    cfg
);
    import idba_pkg::*;

    logic [ID_W-1:0]   base_id_reg;
    logic [IDC_W-1:0]  id_count_reg;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] lim_a;
    logic [SPAN_W-1:0] lim_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_id_reg  <= BASE_ID_RESET;
            id_count_reg <= ID_COUNT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BASE_ID:  base_id_reg  <= cfg_data[ID_W-1:0];
                CFG_ID_COUNT: id_count_reg <= cfg_data[IDC_W-1:0];
                default: ;
            endcase
        end
    end

    // The active count is limited by the map size and by the top of the
    // identifier space above the base.
    always_comb begin
        span  = SPAN_W'(1 << ID_W) - SPAN_W'(base_id_reg);
        lim_a = SPAN_W'(id_count_reg);
        if (lim_a > SPAN_W'(MAP_BITS)) begin
            lim_a = SPAN_W'(MAP_BITS);
        end
        lim_b = (lim_a > span) ? span : lim_a;
        cfg.base_id      = base_id_reg;
        cfg.active_count = lim_b[CNT_W-1:0];
    end

endmodule

// ===== hdl/idba_ctrl.sv =====
module idba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  idba_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  idba_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output idba_pkg::out_word_t m_data,
    output idba_pkg::ram_req_t  ram_req,
    input  idba_pkg::map_word_t ram_rd_data
);
    import idba_pkg::*;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    in_word_t          item_reg, item_next;
    logic [ADDR_W-1:0] scan_addr_reg, scan_addr_next;
    logic [ADDR_W-1:0] data_addr_reg, data_addr_next;
    logic              data_valid_reg, data_valid_next;
    out_word_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    logic [CNT_W-1:0]  n_minus1;
    logic [ADDR_W-1:0] last_word;
    logic [BIT_W-1:0]  last_bit;
    logic              count_zero;
    logic [ID_W-1:0]   offset;
    logic              in_range;
    logic [ADDR_W-1:0] rel_word;
    logic [BIT_W-1:0]  rel_bit;
    logic              issue_ok;
    map_word_t         mask;
    map_word_t         free_bits;
    logic [BIT_W-1:0]  hit_bit;
    logic              hit;
    logic              scan_end;
    logic              clr_last;
    logic              out_free;

    assign count_zero = (cfg.active_count == '0);
    assign n_minus1   = cfg.active_count - CNT_W'(1);
    assign last_word  = ADDR_W'(n_minus1 >> BIT_W);
    assign last_bit   = n_minus1[BIT_W-1:0];
    assign offset     = item_reg.release_id - cfg.base_id;
    assign in_range   = (item_reg.release_id >= cfg.base_id)
                        && (offset < ID_W'(cfg.active_count));
    assign rel_word   = offset[SLOT_W-1:BIT_W];
    assign rel_bit    = offset[BIT_W-1:0];
    assign issue_ok   = (scan_addr_reg <= last_word);
    assign clr_last   = (clr_addr_reg == ADDR_W'(MAP_WORDS - 1));
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        hit_bit = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = (data_addr_reg != last_word) || (BIT_W'(b) <= last_bit);
        end
        free_bits = ~ram_rd_data & mask;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit_bit = BIT_W'(b);
            end
        end
    end

    assign hit      = data_valid_reg && (free_bits != '0);
    assign scan_end = data_valid_reg && (data_addr_reg == last_word);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (item_reg.opcode == OP_ALLOC) begin
                    state_next = count_zero ? S_DONE : S_SCAN;
                end else begin
                    state_next = in_range ? S_REL_WRITE : S_DONE;
                end
            end
            S_SCAN: begin
                if (hit || scan_end) begin
                    state_next = S_DONE;
                end
            end
            S_REL_WRITE: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        clr_addr_next   = clr_addr_reg;
        item_next       = item_reg;
        scan_addr_next  = scan_addr_reg;
        data_addr_next  = data_addr_reg;
        data_valid_next = 1'b0;
        res_next        = res_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        ram_req         = '0;
        s_ready         = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = clr_addr_reg;
                ram_req.wr_data = '0;
                clr_addr_next   = clr_addr_reg + ADDR_W'(1);
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next = s_data;
                end
            end
            S_DECODE: begin
                scan_addr_next = '0;
                if (item_reg.opcode == OP_ALLOC) begin
                    res_next = '{status: ST_FULL, id: '0};
                end else if (in_range) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = rel_word;
                end else begin
                    res_next = '{status: ST_RANGE, id: '0};
                end
            end
            S_SCAN: begin
                ram_req.rd_en   = issue_ok;
                ram_req.rd_addr = scan_addr_reg;
                scan_addr_next  = scan_addr_reg + ADDR_W'(1);
                data_addr_next  = scan_addr_reg;
                data_valid_next = issue_ok;
                if (hit) begin
                    ram_req.rd_en   = 1'b0;
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = data_addr_reg;
                    ram_req.wr_data = ram_rd_data | (map_word_t'(1) << hit_bit);
                    res_next.status = ST_OK;
                    res_next.id     = cfg.base_id + ID_W'({data_addr_reg, hit_bit});
                end else if (scan_end) begin
                    res_next = '{status: ST_FULL, id: '0};
                end
            end
            S_REL_WRITE: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = rel_word;
                ram_req.wr_data = ram_rd_data & ~(map_word_t'(1) << rel_bit);
                res_next.status = ST_OK;
                res_next.id     = item_reg.release_id;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            data_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            data_valid_reg <= data_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        scan_addr_reg <= scan_addr_next;
        data_addr_reg <= data_addr_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
